// File: sv/d2i_pkg.sv
`default_nettype none

package d2i_pkg;

  localparam int unsigned Q_DEPTH = 2;

  localparam int unsigned EXP_W  = 11;
  localparam int unsigned FRAC_W = 52;
  localparam int unsigned SIG_W  = FRAC_W + 1;
  localparam int unsigned INT_W  = 64;
  localparam int unsigned SH_W   = 6;

  localparam logic [EXP_W-1:0] EXP_MAX    = 11'h7ff;
  localparam logic [EXP_W-1:0] SHIFT_BIAS = 11'd1075;
  localparam logic [EXP_W-1:0] LEFT_OVF   = 11'd12;
  localparam logic [EXP_W-1:0] LEFT_LOST  = 11'd64;
  localparam logic [EXP_W-1:0] RIGHT_LOST = 11'd63;

  localparam logic [INT_W-1:0] HALF_WORD = 64'h8000_0000_0000_0000;

  localparam logic [1:0] RM_NEAREST_EVEN = 2'd0;
  localparam logic [1:0] RM_TOWARD_ZERO  = 2'd1;
  localparam logic [1:0] RM_UP           = 2'd2;
  localparam logic [1:0] RM_DOWN         = 2'd3;

  localparam logic [1:0] EXC_NONE     = 2'd0;
  localparam logic [1:0] EXC_INVALID  = 2'd1;
  localparam logic [1:0] EXC_OVERFLOW = 2'd2;
  localparam logic [1:0] EXC_INEXACT  = 2'd3;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_TINY,
    CLS_LEFT,
    CLS_RIGHT
  } cls_t;

  typedef struct packed {
    logic [63:0] operand_bits;
    logic [1:0]  round_mode;
    logic        trap_enable;
  } in_word_t;

  typedef struct packed {
    logic [63:0] int_result;
    logic [1:0]  exception_code;
  } out_word_t;

  typedef struct packed {
    cls_t             cls;
    logic             neg;
    logic [1:0]       mode;
    logic             traps;
    logic [SH_W-1:0]  shamt;
    logic [SIG_W-1:0] sig;
    logic [1:0]       exc;
  } work_t;

endpackage

`default_nettype wire

// File: sv/d2i_front.sv
`default_nettype none

module d2i_front import d2i_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic     q_full,
  output logic          q_push,
  output work_t         q_word
);

  logic             f_vld_r, f_vld_nxt;
  work_t            f_work_r, f_work_nxt;
  logic             accept;
  logic [EXP_W-1:0] ex;
  logic [EXP_W-1:0] lsh;
  logic [EXP_W-1:0] rsh;
  logic             frac_nz;
  logic             traps;

  assign in_stall = f_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_vld_r && !q_full;
  assign q_word   = f_work_r;

  assign ex      = in_word.operand_bits[62:52];
  assign frac_nz = |in_word.operand_bits[51:0];
  assign traps   = in_word.trap_enable;
  assign lsh     = ex - SHIFT_BIAS;
  assign rsh     = SHIFT_BIAS - ex;

  always_comb begin
    f_work_nxt.neg   = in_word.operand_bits[63];
    f_work_nxt.mode  = in_word.round_mode;
    f_work_nxt.traps = traps;
    f_work_nxt.sig   = {1'b1, in_word.operand_bits[51:0]};
    f_work_nxt.shamt = '0;
    f_work_nxt.cls   = CLS_ZERO;
    f_work_nxt.exc   = EXC_NONE;
    if (ex == EXP_MAX) begin
      f_work_nxt.exc = frac_nz ? EXC_INVALID : (traps ? EXC_OVERFLOW : EXC_NONE);
    end else if (ex == '0) begin
      if (frac_nz) begin
        f_work_nxt.cls = CLS_TINY;
        f_work_nxt.exc = traps ? EXC_INEXACT : EXC_NONE;
      end
    end else if (ex >= SHIFT_BIAS) begin
      if (lsh >= LEFT_LOST) begin
        f_work_nxt.exc = traps ? EXC_OVERFLOW : EXC_NONE;
      end else begin
        f_work_nxt.cls   = CLS_LEFT;
        f_work_nxt.shamt = lsh[SH_W-1:0];
        f_work_nxt.exc   = (traps && lsh >= LEFT_OVF) ? EXC_OVERFLOW : EXC_NONE;
      end
    end else begin
      if (rsh >= RIGHT_LOST) begin
        f_work_nxt.cls = CLS_TINY;
        f_work_nxt.exc = traps ? EXC_INEXACT : EXC_NONE;
      end else begin
        f_work_nxt.cls   = CLS_RIGHT;
        f_work_nxt.shamt = rsh[SH_W-1:0];
      end
    end
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (q_push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_work_r <= f_work_nxt;
    end
  end

  // without traps only invalid may be reported
  a_no_trap_exc: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r && !f_work_r.traps |->
      f_work_r.exc == EXC_NONE || f_work_r.exc == EXC_INVALID)
    else $error("trap-only code without traps");

endmodule

`default_nettype wire

// File: sv/d2i_queue.sv
`default_nettype none

module d2i_queue import d2i_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t push_word,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output work_t      pop_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: sv/d2i_back.sv
`default_nettype none

module d2i_back import d2i_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire work_t q_word,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_word_t  out_word
);

  logic             a_vld_r, a_vld_nxt;
  logic [INT_W-1:0] a_mag_r, a_mag_nxt;
  logic             a_inc_r, a_inc_nxt;
  logic             a_neg_r;
  logic [1:0]       a_exc_r, a_exc_nxt;
  logic             o_vld_r, o_vld_nxt;
  out_word_t        o_word_r, o_word_nxt;
  logic             load_a, load_o;
  logic [INT_W-1:0] rnd;
  logic [INT_W-1:0] lsh;
  logic [2*INT_W-1:0] wide;
  logic             rnd_nz;

  assign load_o = !o_vld_r || !out_stall;
  assign load_a = !a_vld_r || load_o;
  assign q_pop  = !q_empty && load_a;

  assign out_valid = o_vld_r;
  assign out_word  = o_word_r;

  // right shift keeps the dropped bits left-aligned in the low word
  assign lsh  = {{(INT_W-SIG_W){1'b0}}, q_word.sig} << q_word.shamt;
  assign wide = {{(INT_W-SIG_W){1'b0}}, q_word.sig, {INT_W{1'b0}}} >> q_word.shamt;

  always_comb begin
    a_mag_nxt = '0;
    rnd       = '0;
    unique case (q_word.cls)
      CLS_ZERO: begin
        a_mag_nxt = '0;
      end
      CLS_TINY: begin
        rnd = INT_W'(1);
      end
      CLS_LEFT: begin
        a_mag_nxt = lsh;
      end
      CLS_RIGHT: begin
        a_mag_nxt = wide[2*INT_W-1:INT_W];
        rnd       = wide[INT_W-1:0];
      end
    endcase
    rnd_nz    = |rnd;
    a_inc_nxt = 1'b0;
    if (rnd_nz) begin
      unique case (q_word.mode)
        RM_NEAREST_EVEN: a_inc_nxt = (rnd == HALF_WORD) ? a_mag_nxt[0] : rnd[INT_W-1];
        RM_TOWARD_ZERO:  a_inc_nxt = 1'b0;
        RM_UP:           a_inc_nxt = !q_word.neg;
        RM_DOWN:         a_inc_nxt = q_word.neg;
      endcase
    end
    if (q_word.cls == CLS_RIGHT) begin
      a_exc_nxt = (q_word.traps && rnd_nz) ? EXC_INEXACT : EXC_NONE;
    end else begin
      a_exc_nxt = q_word.exc;
    end
  end

  // -(m + i) == ~m + 1 - i
  always_comb begin
    if (a_neg_r) begin
      o_word_nxt.int_result = ~a_mag_r + {{(INT_W-1){1'b0}}, ~a_inc_r};
    end else begin
      o_word_nxt.int_result = a_mag_r + {{(INT_W-1){1'b0}}, a_inc_r};
    end
    o_word_nxt.exception_code = a_exc_r;
  end

  assign a_vld_nxt = load_a ? !q_empty : a_vld_r;
  assign o_vld_nxt = load_o ? a_vld_r : o_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_mag_r <= a_mag_nxt;
      a_inc_r <= a_inc_nxt;
      a_neg_r <= q_word.neg;
      a_exc_r <= a_exc_nxt;
    end
    if (load_o && a_vld_r) begin
      o_word_r <= o_word_nxt;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !load_o |=> a_vld_r && $stable(a_mag_r))
    else $error("round stage word lost under stall");

endmodule

`default_nettype wire

// File: sv/double_to_int64_convert_core.sv
// Double to int64 converter.
// Path from accept to out_valid: classify, queue, shift/round, negate.
// Throughput: one word per cycle while neither side stalls; each stage is one register wide, queue holds QDEPTH words.
// Front and back stall independently through the queue.
// Reset: synchronous active-low rst_n clears all valid bits and queue pointers.
`default_nettype none

module double_to_int64_convert_core import d2i_pkg::*; #(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  logic  q_full, q_empty, q_push, q_pop;
  work_t q_in_word, q_out_word;

  d2i_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_in_word)
  );

  d2i_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_word  (q_out_word)
  );

  d2i_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_word    (q_out_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: tb/sv/d2i_conversion_checker.sv
module d2i_conversion_checker import d2i_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  output int unsigned outstanding,
  output int unsigned fail_total,
  output int unsigned words_checked,
  output logic [3:0]  exc_seen
);

  localparam int BIAS_PLUS_FRAC = 1075;
  localparam int WRAP_SHIFT     = 63;
  localparam int TINY_SHIFT     = 63;

  out_word_t   predicted_words[$];
  int unsigned fails = 0;
  int unsigned checked = 0;
  logic [3:0]  seen = '0;

  function automatic logic [63:0] round_by_mode(input logic [63:0] mag, input logic [63:0] rnd,
                                                input logic [1:0] mode, input logic neg);
    case (mode)
      RM_NEAREST_EVEN: begin
        if (rnd == HALF_WORD) mag = mag + {63'd0, mag[0]};
        else if (rnd > HALF_WORD) mag = mag + 64'd1;
      end
      RM_TOWARD_ZERO: ;
      RM_UP: begin
        if (!neg) mag = mag + 64'd1;
      end
      default: begin
        if (neg) mag = mag + 64'd1;
      end
    endcase
    return mag;
  endfunction

  function automatic out_word_t convert_double(input in_word_t w);
    logic        neg;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [63:0] sig64;
    logic [63:0] mag;
    logic [63:0] rnd;
    logic [1:0]  exc;
    int          sh;
    out_word_t   r;
    neg   = w.operand_bits[63];
    expo  = w.operand_bits[62:52];
    frac  = w.operand_bits[51:0];
    sig64 = {11'd0, 1'b1, frac};
    mag   = '0;
    rnd   = '0;
    exc   = EXC_NONE;
    if (expo == EXP_MAX) begin
      if (frac != '0) exc = EXC_INVALID;
      else if (w.trap_enable) exc = EXC_OVERFLOW;
    end else if (expo != '0 || frac != '0) begin
      if (expo == '0) begin
        // denormal: only a sticky bit survives
        if (w.trap_enable) exc = EXC_INEXACT;
        mag = round_by_mode(64'd0, 64'd1, w.round_mode, neg);
      end else begin
        sh = int'(expo) - BIAS_PLUS_FRAC;
        if (sh >= 0) begin
          if (sh < 64) mag = sig64 << sh;
          if (w.trap_enable && (sh >= WRAP_SHIFT || (mag >> sh) != sig64)) exc = EXC_OVERFLOW;
        end else begin
          if (-sh < TINY_SHIFT) begin
            mag = sig64 >> (-sh);
            rnd = sig64 << (64 + sh);
          end else begin
            mag = '0;
            rnd = 64'd1;
          end
          if (rnd != '0) begin
            if (w.trap_enable) exc = EXC_INEXACT;
            mag = round_by_mode(mag, rnd, w.round_mode, neg);
          end
        end
      end
      if (neg) mag = -mag;
    end
    r.int_result     = mag;
    r.exception_code = exc;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    fails++;
    $display("mismatch %0d at %0t on %s: got %h, expected %h", fails, $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (!$isunknown(out_word.exception_code)) seen[out_word.exception_code] = 1'b1;
        if (predicted_words.size() == 0) begin
          flag_mismatch("unexpected word", out_word.int_result, '0);
        end else begin
          want = predicted_words.pop_front();
          if (out_word.int_result !== want.int_result)
            flag_mismatch("int_result", out_word.int_result, want.int_result);
          if (out_word.exception_code !== want.exception_code)
            flag_mismatch("exception_code", {62'd0, out_word.exception_code},
                          {62'd0, want.exception_code});
        end
      end
      if (in_valid && !in_stall) predicted_words.push_back(convert_double(in_word));
    end
    outstanding   <= predicted_words.size();
    fail_total    <= fails;
    words_checked <= checked;
    exc_seen      <= seen;
  end

endmodule

// File: tb/sv/tb_double_to_int64_convert_core.sv
module tb_double_to_int64_convert_core;
  import d2i_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int unsigned outstanding;
  int unsigned fail_total;
  int unsigned words_checked;
  logic [3:0]  exc_seen;

  int unsigned sent_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int          boundary_exps [14] = '{1, 1011, 1012, 1013, 1074, 1075, 1076,
                                      1085, 1086, 1087, 1137, 1138, 1139, 2046};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_to_int64_convert_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  d2i_conversion_checker conv_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .outstanding   (outstanding),
    .fail_total    (fail_total),
    .words_checked (words_checked),
    .exc_seen      (exc_seen)
  );

  task automatic send_double(input logic [63:0] bits, input logic [1:0] mode, input logic trap);
    in_word_t    w;
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.operand_bits = bits;
    w.round_mode   = mode;
    w.trap_enable  = trap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  initial begin
    int          kind;
    int          ex;
    int          rs;
    logic        sign;
    logic [63:0] f;
    logic [10:0] ex_bits;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_double(64'h0000_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'h8000_0000_0000_0000, RM_DOWN, 1'b1);
    send_double(64'h7ff0_0000_0000_0000, RM_UP, 1'b1);
    send_double(64'hfff0_0000_0000_0000, RM_TOWARD_ZERO, 1'b0);
    send_double(64'h7ff8_0000_0000_0000, RM_NEAREST_EVEN, 1'b0);
    send_double(64'hfff0_0000_0000_0001, RM_DOWN, 1'b1);
    send_double(64'h0000_0000_0000_0001, RM_UP, 1'b1);
    send_double(64'h800f_ffff_ffff_ffff, RM_DOWN, 1'b0);
    send_double(64'h800f_ffff_ffff_ffff, RM_NEAREST_EVEN, 1'b1);
    send_double(64'h3fe0_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'h3ff8_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'hc004_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'hbff0_0000_0000_0000, RM_TOWARD_ZERO, 1'b1);
    send_double(64'h3fdf_ffff_ffff_ffff, RM_UP, 1'b1);
    send_double(64'h4330_0000_0000_0000, RM_DOWN, 1'b1);
    send_double(64'h43df_ffff_ffff_ffff, RM_TOWARD_ZERO, 1'b1);
    send_double(64'h43e0_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'hc3e0_0000_0000_0000, RM_UP, 1'b1);
    send_double(64'h43f0_0000_0000_0000, RM_NEAREST_EVEN, 1'b1);
    send_double(64'h4720_0000_0000_0000, RM_TOWARD_ZERO, 1'b1);
    send_double(64'h4730_0000_0000_0000, RM_UP, 1'b1);
    send_double(64'h7fef_ffff_ffff_ffff, RM_DOWN, 1'b0);
    send_double(64'h3f40_0000_0000_0000, RM_UP, 1'b1);
    send_double(64'h8010_0000_0000_0000, RM_DOWN, 1'b1);
    send_double(64'h3f5f_ffff_ffff_ffff, RM_NEAREST_EVEN, 1'b1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 99);
      sign = $urandom_range(0, 1);
      f    = {$urandom, $urandom};
      if (kind < 35) begin
        ex = $urandom_range(1005, 1145);
      end else if (kind < 45) begin
        ex = boundary_exps[$urandom_range(0, 13)];
      end else if (kind < 55) begin
        // dropped bits exactly one half
        ex = $urandom_range(1023, 1074);
        rs = 1075 - ex;
        f  = (f & ~((64'd1 << rs) - 64'd1)) | (64'd1 << (rs - 1));
      end else if (kind < 65) begin
        ex = $urandom_range(1023, 1085);
        if (ex < 1075) f = f & ~((64'd1 << (1075 - ex)) - 64'd1);
      end else if (kind < 70) begin
        ex = 0;
        f  = '0;
      end else if (kind < 75) begin
        ex = 2047;
        if ($urandom_range(0, 1) == 0) f = '0;
      end else if (kind < 85) begin
        ex = 0;
        if (f[51:0] == '0) f = 64'd1;
      end else begin
        ex   = f[62:52];
        sign = f[63];
        f    = {$urandom, $urandom};
      end
      ex_bits = ex[10:0];
      send_double({sign, ex_bits, f[51:0]}, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d doubles (corner cases, then random classes, modes and traps);",
             sent_count);
    $display("%0d results compared, exception codes seen (bit per code): %b",
             words_checked, exc_seen);
    if (fail_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
sv/d2i_pkg.sv
sv/d2i_front.sv
sv/d2i_queue.sv
sv/d2i_back.sv
sv/double_to_int64_convert_core.sv
tb/sv/d2i_conversion_checker.sv
tb/sv/tb_double_to_int64_convert_core.sv
